[src/plec_pkg.sv]
// ----------------------------------------------------------------------------
// plec_pkg
// Shared types and constants for the piecewise linear error correction block.
// ----------------------------------------------------------------------------
package plec_pkg;

  localparam int unsigned DefTableDepth = 256;
  localparam int unsigned MagW          = 33;
  localparam int unsigned ProdW         = 2 * MagW;
  localparam int unsigned CntW          = 7;
  localparam logic [CntW-1:0] MulSteps  = CntW'(MagW);
  localparam logic [CntW-1:0] DivSteps  = CntW'(ProdW);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_CORRECT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ABOVE = 2'd1,
    ST_NO_LEFT  = 2'd2,
    ST_ZERO_SPN = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] err;
  } brk_t;

  typedef struct packed {
    logic       shift;
    logic       load;
    brk_t       data;
  } chain_ctl_t;

endpackage

[src/plec_cell.sv]
// ----------------------------------------------------------------------------
// plec_cell
// One breakpoint storage cell of the rotating chain.
// ----------------------------------------------------------------------------
module plec_cell (
  input  logic          clk_i,
  input  logic          load_i,
  input  logic          shift_i,
  input  plec_pkg::brk_t load_data_i,
  input  plec_pkg::brk_t shift_data_i,
  output plec_pkg::brk_t data_o
);
  import plec_pkg::*;

  brk_t data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= shift_data_i;
    end else if (load_i) begin
      data_q <= load_data_i;
    end
  end

  assign data_o = data_q;

endmodule

[src/plec_chain.sv]
// ----------------------------------------------------------------------------
// plec_chain
// Ring of breakpoint cells; a shift rotates every entry one place toward
// cell 0, and a full circle restores the original alignment.
// ----------------------------------------------------------------------------
module plec_chain #(
  parameter int unsigned Depth = plec_pkg::DefTableDepth,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  plec_pkg::chain_ctl_t ctl_i,
  input  logic [IdxW-1:0]    load_idx_i,
  output plec_pkg::brk_t     head_o
);
  import plec_pkg::*;

  brk_t cell_data [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    plec_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (ctl_i.load && (load_idx_i == IdxW'(i))),
      .shift_i     (ctl_i.shift),
      .load_data_i (ctl_i.data),
      .shift_data_i(cell_data[(i + 1) % Depth]),
      .data_o      (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

[src/piecewise_linear_error_correction.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_error_correction
// Breakpoint table with linear interpolation and saturating correction.
// ----------------------------------------------------------------------------
// Clear and append requests leave the block idle. A correct request stalls
// the input from the time it is taken until the block is idle again. The
// breakpoint ring rotates once past its head to find the bracket. A setup
// state follows, then a shift-add multiplier and a restoring divider form
// the slope term. The finish state subtracts and saturates, and the done
// state moves the result into the output register. Queries that find no
// bracket skip the arithmetic. A finished result sits in an output register,
// so new requests are taken while it waits; a query that finishes while that
// register is still held waits for it to drain.
module piecewise_linear_error_correction #(
  parameter int unsigned TableDepth = plec_pkg::DefTableDepth,
  localparam int unsigned IdxW = $clog2(TableDepth),
  localparam int unsigned CountW = $clog2(TableDepth + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic signed [31:0] position_i,
  input  logic signed [31:0] amount_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] corrected_value_o,
  output logic [1:0]  status_o
);
  import plec_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_CALC = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CountW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic found_q, first_q;
  brk_t left_q, right_q, head;
  logic signed [31:0] qpos_q, amt_q, res_q;
  status_e stat_q;
  logic [CntW-1:0] step_q;
  logic [ProdW-1:0] acc_q, mcand_q;
  logic [MagW-1:0] mplier_q, span_mag_q, rem_q;
  logic neg_q;
  logic out_valid_q;
  logic signed [31:0] out_val_q;
  status_e out_stat_q;
  chain_ctl_t ctl;
  logic accept, full;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign full = (count_q == CountW'(TableDepth));

  assign ctl.shift = (state_q == S_SCAN);
  assign ctl.load  = accept && (cmd_e'(cmd_i) == CMD_APPEND) && !full;
  assign ctl.data  = '{pos: position_i, err: amount_i};

  plec_chain #(.Depth(TableDepth)) u_chain (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .load_idx_i(count_q[IdxW-1:0]),
    .head_o    (head)
  );

  // bracket arithmetic, all 33-bit signed
  logic signed [MagW-1:0] span, delta, rise;
  assign span  = {right_q.pos[31], right_q.pos} - {left_q.pos[31], left_q.pos};
  assign delta = {qpos_q[31], qpos_q} - {left_q.pos[31], left_q.pos};
  assign rise  = {right_q.err[31], right_q.err} - {left_q.err[31], left_q.err};

  logic [MagW:0] rem_sh;
  logic rem_ge;
  assign rem_sh = {rem_q, acc_q[ProdW-1]};
  assign rem_ge = rem_sh >= {1'b0, span_mag_q};

  logic signed [MagW+1:0] err_v, res_v;
  assign err_v = neg_q ? ({{3{left_q.err[31]}}, left_q.err} - {2'b00, acc_q[MagW-1:0]})
                       : ({{3{left_q.err[31]}}, left_q.err} + {2'b00, acc_q[MagW-1:0]});
  assign res_v = {{3{amt_q[31]}}, amt_q} - err_v;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept && cmd_e'(cmd_i) == CMD_CORRECT) state_d = S_SCAN;
      S_SCAN: if (idx_q == IdxW'(TableDepth - 1)) state_d = S_CALC;
      S_CALC: begin
        if (!found_q || first_q || span == '0) state_d = S_DONE;
        else state_d = S_MUL;
      end
      S_MUL:  if (step_q == MulSteps - 1'b1) state_d = S_DIV;
      S_DIV:  if (step_q == DivSteps - 1'b1) state_d = S_FIN;
      S_FIN:  state_d = S_DONE;
      S_DONE: if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept && cmd_e'(cmd_i) == CMD_CLEAR) begin
        count_q <= '0;
      end else if (ctl.load) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == S_DONE && state_d == S_IDLE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        idx_q   <= '0;
        found_q <= 1'b0;
        first_q <= 1'b0;
        qpos_q  <= position_i;
        amt_q   <= amount_i;
      end
      S_SCAN: begin
        idx_q <= idx_q + 1'b1;
        if (!found_q && CountW'(idx_q) < count_q) begin
          if (head.pos > qpos_q) begin
            found_q <= 1'b1;
            first_q <= (idx_q == '0);
            right_q <= head;
          end else begin
            left_q <= head;
          end
        end
      end
      S_CALC: begin
        res_q      <= amt_q;
        step_q     <= '0;
        acc_q      <= '0;
        rem_q      <= '0;
        mcand_q    <= {{(ProdW-MagW){1'b0}}, delta[MagW-1] ? -delta : delta};
        mplier_q   <= rise[MagW-1] ? -rise : rise;
        span_mag_q <= span[MagW-1] ? -span : span;
        neg_q      <= ((delta[MagW-1] != rise[MagW-1]) != span[MagW-1])
                      && delta != '0 && rise != '0;
        if (!found_q) stat_q <= ST_NO_ABOVE;
        else if (first_q) stat_q <= ST_NO_LEFT;
        else if (span == '0) stat_q <= ST_ZERO_SPN;
        else stat_q <= ST_OK;
      end
      S_MUL: begin
        step_q   <= (step_q == MulSteps - 1'b1) ? '0 : step_q + 1'b1;
        if (mplier_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
      end
      S_DIV: begin
        step_q <= step_q + 1'b1;
        acc_q  <= {acc_q[ProdW-2:0], rem_ge};
        rem_q  <= rem_ge ? MagW'(rem_sh - {1'b0, span_mag_q}) : rem_sh[MagW-1:0];
      end
      S_FIN: begin
        if (res_v > 35'sd2147483647) res_q <= 32'sh7fffffff;
        else if (res_v < -35'sd2147483648) res_q <= 32'sh80000000;
        else res_q <= res_v[31:0];
      end
      S_DONE: begin
        if (state_d == S_IDLE) begin
          out_val_q  <= res_q;
          out_stat_q <= stat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign corrected_value_o = out_val_q;
  assign status_o          = out_stat_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TableDepth)) else $error("entry count overflow");
  a_query_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && cmd_e'(cmd_i) == CMD_CORRECT |=> state_q == S_SCAN)
    else $error("query did not start scan");
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result without finished query");

endmodule
